// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked on the same edge
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked on the next edge
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/brea_pkg.sv
// shared types, constants and stick decode for the button remapper
`timescale 1ns / 1ps

package brea_pkg;

  localparam int unsigned NumButtons = 16;
  localparam int unsigned MapWidth   = 64;

  typedef logic [NumButtons-1:0] btn_t;
  typedef logic [7:0]            cnt_t;
  typedef logic [3:0]            dir_t;

  // reset values of the registers
  localparam cnt_t FirstDelayRst = 8'd12;
  localparam cnt_t StartIvlRst   = 8'd6;
  localparam cnt_t MinIvlRst     = 8'd2;
  localparam logic [MapWidth-1:0] MapRst = 64'hFEDCBA9876543210;

  // stick thresholds, half of full scale
  localparam logic signed [15:0] StickHi = 16'sd16383;
  localparam logic signed [15:0] StickLo = -16'sd16384;

  // direction bits within a stick group
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  // base of the right stick group
  localparam int unsigned RightBase = 4;

  typedef enum logic [2:0] {
    RegLeftEn    = 3'd0,
    RegRightEn   = 3'd1,
    RegMap       = 3'd2,
    RegFirstDly  = 3'd3,
    RegStartIvl  = 3'd4,
    RegMinIvl    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                left_en;
    logic                right_en;
    logic [MapWidth-1:0] map;
  } front_cfg_t;

  typedef struct packed {
    cnt_t first_delay;
    cnt_t start_ivl;
    cnt_t min_ivl;
  } back_cfg_t;

  typedef struct packed {
    btn_t held;
    btn_t pressed;
    btn_t released;
    btn_t fire;
  } result_t;

  // one-hot direction of a stick beyond half scale, zero when near center
  function automatic dir_t stick_dir(logic signed [15:0] x, logic signed [15:0] y);
    logic signed [16:0] xe;
    logic signed [16:0] ye;
    logic signed [16:0] nx;
    logic               active;
    logic               anti;
    dir_t               d;
    xe     = {x[15], x};
    ye     = {y[15], y};
    nx     = -xe;
    active = (x < StickLo) || (x >= StickHi) || (y < StickLo) || (y >= StickHi);
    anti   = (nx >= ye);
    d      = '0;
    if (active) begin
      if (xe >= ye) begin
        d[anti ? DirDown : DirRight] = 1'b1;
      end else begin
        d[anti ? DirLeft : DirUp] = 1'b1;
      end
    end
    return d;
  endfunction

endpackage

// File: design/brea_front.sv
// front end: stick decode and button remap of one frame
`timescale 1ns / 1ps

module brea_front (
  input  brea_pkg::front_cfg_t cfg_i,
  input  brea_pkg::btn_t       raw_i,
  input  logic signed [15:0]   left_x_i,
  input  logic signed [15:0]   left_y_i,
  input  logic signed [15:0]   right_x_i,
  input  logic signed [15:0]   right_y_i,
  output brea_pkg::btn_t       held_o
);

  brea_pkg::btn_t raw_all;
  brea_pkg::dir_t left_dir;
  brea_pkg::dir_t right_dir;

  // stick directions folded into the raw bits
  always_comb begin
    left_dir  = cfg_i.left_en  ? brea_pkg::stick_dir(left_x_i, left_y_i)   : '0;
    right_dir = cfg_i.right_en ? brea_pkg::stick_dir(right_x_i, right_y_i) : '0;
    raw_all   = raw_i;
    raw_all[3:0] = raw_i[3:0] | left_dir;
    raw_all[brea_pkg::RightBase +: 4] = raw_i[brea_pkg::RightBase +: 4] | right_dir;
  end

  // each set physical button lights its target slot
  always_comb begin
    held_o = '0;
    for (int i = 0; i < brea_pkg::NumButtons; i++) begin
      if (raw_all[i]) begin
        held_o[cfg_i.map[4*i +: 4]] = 1'b1;
      end
    end
  end

endmodule

// File: design/brea_queue.sv
// two-entry queue of remapped button sets between front and back
`timescale 1ns / 1ps

module brea_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brea_pkg::btn_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output brea_pkg::btn_t data_o,
  output logic           empty_o
);

  brea_pkg::btn_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: design/brea_back.sv
// back end: edges, typematic counters and the result queue
`timescale 1ns / 1ps

module brea_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brea_pkg::back_cfg_t   cfg_i,
  input  logic                  in_empty_i,
  input  brea_pkg::btn_t        in_held_i,
  output logic                  in_pop_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output brea_pkg::result_t     result_o
);

  brea_pkg::cnt_t    cnt_q [brea_pkg::NumButtons];
  brea_pkg::cnt_t    cnt_d [brea_pkg::NumButtons];
  brea_pkg::cnt_t    ivl_q [brea_pkg::NumButtons];
  brea_pkg::cnt_t    ivl_d [brea_pkg::NumButtons];
  brea_pkg::btn_t    prev_q;
  brea_pkg::btn_t    fire;
  brea_pkg::result_t res;

  brea_pkg::result_t ent_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        ocnt_q;
  logic              out_pop, out_room, step;

  // result queue handshake
  assign empty_o  = (ocnt_q == 2'd0);
  assign result_o = ent_q[rd_ptr_q];
  assign out_pop  = pop_i && !empty_o;
  assign out_room = (ocnt_q != 2'd2) || out_pop;
  assign step     = !in_empty_i && out_room;
  assign in_pop_o = step;

  // per-button repeat lanes
  always_comb begin
    fire = '0;
    for (int i = 0; i < brea_pkg::NumButtons; i++) begin
      cnt_d[i] = cnt_q[i];
      ivl_d[i] = ivl_q[i];
      if (in_held_i[i]) begin
        fire[i]  = (cnt_q[i] == cfg_i.first_delay) || (cnt_q[i] == 8'd1);
        cnt_d[i] = cnt_q[i] - 8'd1;
        if (cnt_q[i] == 8'd1) begin
          cnt_d[i] = ivl_q[i];
          ivl_d[i] = (ivl_q[i] <= cfg_i.min_ivl) ? cfg_i.min_ivl : ivl_q[i] - 8'd1;
        end
      end else begin
        cnt_d[i] = cfg_i.first_delay;
        ivl_d[i] = cfg_i.start_ivl;
      end
    end
  end

  // result word
  always_comb begin
    res.held     = in_held_i;
    res.pressed  = in_held_i & ~prev_q;
    res.released = prev_q & ~in_held_i;
    res.fire     = fire;
  end

  // lane state and previous frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      for (int i = 0; i < brea_pkg::NumButtons; i++) begin
        cnt_q[i] <= brea_pkg::FirstDelayRst;
        ivl_q[i] <= brea_pkg::StartIvlRst;
      end
    end else if (step) begin
      prev_q <= in_held_i;
      for (int i = 0; i < brea_pkg::NumButtons; i++) begin
        cnt_q[i] <= cnt_d[i];
        ivl_q[i] <= ivl_d[i];
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ocnt_q   <= 2'd0;
    end else begin
      if (step)    wr_ptr_q <= ~wr_ptr_q;
      if (out_pop) rd_ptr_q <= ~rd_ptr_q;
      if (step && !out_pop)      ocnt_q <= ocnt_q + 2'd1;
      else if (out_pop && !step) ocnt_q <= ocnt_q - 2'd1;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (step) ent_q[wr_ptr_q] <= res;
  end

endmodule

// File: design/button_remap_edge_autorepeat.sv
// top level: button remapper with edges and typematic repeat
//
//   channel   handshake          payload
//   input     push / full        raw_buttons_i, left_x_i, left_y_i, right_x_i, right_y_i
//   result    empty / pop        held_o, pressed_edge_o, released_edge_o, repeat_fire_o
//   config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// one frame per cycle sustained while results are popped; the repeat lanes update all buttons at once
// a result shows on the result ports once its frame has passed the frame queue and the result queue
// two-entry queues sit between front and back and after the back end
// reset clears the queue counts and the previous frame at once; counters start at 12 and intervals at 6
// full rises only when both frame queue entries are taken while the result side stalls
`timescale 1ns / 1ps

module button_remap_edge_autorepeat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        raw_buttons_i,
  input  logic signed [15:0] left_x_i,
  input  logic signed [15:0] left_y_i,
  input  logic signed [15:0] right_x_i,
  input  logic signed [15:0] right_y_i,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        held_o,
  output logic [15:0]        pressed_edge_o,
  output logic [15:0]        released_edge_o,
  output logic [15:0]        repeat_fire_o
);

  brea_pkg::front_cfg_t front_cfg_q;
  brea_pkg::back_cfg_t  back_cfg_q;
  brea_pkg::btn_t       front_held;
  brea_pkg::btn_t       mid_held;
  logic                 mid_empty, mid_pop;
  brea_pkg::result_t    result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_cfg_q.left_en    <= 1'b0;
      front_cfg_q.right_en   <= 1'b0;
      front_cfg_q.map        <= brea_pkg::MapRst;
      back_cfg_q.first_delay <= brea_pkg::FirstDelayRst;
      back_cfg_q.start_ivl   <= brea_pkg::StartIvlRst;
      back_cfg_q.min_ivl     <= brea_pkg::MinIvlRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brea_pkg::RegLeftEn:   front_cfg_q.left_en    <= cfg_data_i[0];
        brea_pkg::RegRightEn:  front_cfg_q.right_en   <= cfg_data_i[0];
        brea_pkg::RegMap:      front_cfg_q.map        <= cfg_data_i;
        brea_pkg::RegFirstDly: back_cfg_q.first_delay <= cfg_data_i[7:0];
        brea_pkg::RegStartIvl: back_cfg_q.start_ivl   <= cfg_data_i[7:0];
        brea_pkg::RegMinIvl:   back_cfg_q.min_ivl     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // frame decode
  brea_front u_front (
    .cfg_i     (front_cfg_q),
    .raw_i     (raw_buttons_i),
    .left_x_i  (left_x_i),
    .left_y_i  (left_y_i),
    .right_x_i (right_x_i),
    .right_y_i (right_y_i),
    .held_o    (front_held)
  );

  // frame queue
  brea_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_held),
    .full_o  (full),
    .pop_i   (mid_pop),
    .data_o  (mid_held),
    .empty_o (mid_empty)
  );

  // repeat engine and result queue
  brea_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (back_cfg_q),
    .in_empty_i (mid_empty),
    .in_held_i  (mid_held),
    .in_pop_o   (mid_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result)
  );

  assign held_o          = result.held;
  assign pressed_edge_o  = result.pressed;
  assign released_edge_o = result.released;
  assign repeat_fire_o   = result.fire;

endmodule

// File: design/brea_checker.sv
// port-level checks of the button remapper, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brea_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [15:0] held_o,
  input logic [15:0] pressed_edge_o,
  input logic [15:0] released_edge_o,
  input logic [15:0] repeat_fire_o
);

  logic [15:0] prev_q;
  logic [2:0]  pending_q;
  logic        in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // held set of the last word taken, and words in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      pending_q <= 3'd0;
    end else begin
      if (out_acc) prev_q <= held_o;
      if (in_acc && !out_acc)      pending_q <= pending_q + 3'd1;
      else if (out_acc && !in_acc) pending_q <= pending_q - 3'd1;
    end
  end

  `ASSERT_IMPL(a_edges, clk_i, rst_ni, out_acc, (pressed_edge_o == (held_o & ~prev_q)) && (released_edge_o == (prev_q & ~held_o)), "edges disagree with held sets")
  `ASSERT_IMPL(a_fire_held, clk_i, rst_ni, !empty, (repeat_fire_o & ~held_o) == 16'd0, "repeat on a button not held")
  `ASSERT_IMPL(a_no_phantom, clk_i, rst_ni, !empty, pending_q != 3'd0, "result without a frame")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(held_o) && $stable(repeat_fire_o), "stalled result changed")

endmodule

bind button_remap_edge_autorepeat brea_checker u_brea_checker (.*);

// File: bench/button_remap_edge_autorepeat_tb.sv
// testbench for the button remapper: directed and random frames checked against a predictor
`timescale 1ns / 1ps

module button_remap_edge_autorepeat_tb;

  // register indexes that the block does not decode
  localparam logic [2:0] RegSpare6 = 3'd6;
  localparam logic [2:0] RegSpare7 = 3'd7;

  // cycles without any accepted word before the run is abandoned
  localparam int unsigned IdleLimit = 5000;

  typedef struct packed {
    logic [15:0] raw;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
  } frame_t;

  typedef struct {
    logic           left_en;
    logic           right_en;
    logic [63:0]    map;
    brea_pkg::cnt_t first_dly;
    brea_pkg::cnt_t start_ivl;
    brea_pkg::cnt_t min_ivl;
  } settings_t;

  typedef enum int {
    PopSteady,
    PopCoin,
    PopPeriodic,
    PopBursty
  } pop_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [63:0] cfg_data_i    = '0;
  logic        push          = 1'b0;
  logic        full;
  logic [15:0] raw_buttons_i = '0;
  logic [15:0] left_x_i      = '0;
  logic [15:0] left_y_i      = '0;
  logic [15:0] right_x_i     = '0;
  logic [15:0] right_y_i     = '0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [15:0] held_o;
  logic [15:0] pressed_edge_o;
  logic [15:0] released_edge_o;
  logic [15:0] repeat_fire_o;

  // frames waiting to be pushed and results waiting to be popped
  frame_t            pending_frames[$];
  brea_pkg::result_t predicted_results[$];

  // predictor copy of the registers and the per-button state
  settings_t      regs;
  brea_pkg::btn_t last_held;
  brea_pkg::cnt_t countdown[brea_pkg::NumButtons];
  brea_pkg::cnt_t interval[brea_pkg::NumButtons];

  // stimulus state: buttons and sticks that stay put across frames
  brea_pkg::btn_t hold_mask;
  logic [15:0]    stick_lx, stick_ly, stick_rx, stick_ry;

  frame_t            cur_frame;
  int                burst_left = 0;
  int                gap_left   = 0;
  pop_mode_e         pop_mode   = PopSteady;
  int                mode_left  = 0;
  int                stall_left = 0;
  brea_pkg::result_t want;
  int                mismatches = 0;
  int unsigned       idle_cycles = 0;

  button_remap_edge_autorepeat u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .raw_buttons_i  (raw_buttons_i),
    .left_x_i       (left_x_i),
    .left_y_i       (left_y_i),
    .right_x_i      (right_x_i),
    .right_y_i      (right_y_i),
    .empty          (empty),
    .pop            (pop),
    .held_o         (held_o),
    .pressed_edge_o (pressed_edge_o),
    .released_edge_o(released_edge_o),
    .repeat_fire_o  (repeat_fire_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one-hot direction of a stick past half scale, zero near center
  function automatic brea_pkg::dir_t decode_stick(input logic [15:0] x, input logic [15:0] y);
    int             xi;
    int             yi;
    brea_pkg::dir_t d;
    xi = $signed(x);
    yi = $signed(y);
    d  = '0;
    if (xi < int'(brea_pkg::StickLo) || xi >= int'(brea_pkg::StickHi) ||
        yi < int'(brea_pkg::StickLo) || yi >= int'(brea_pkg::StickHi)) begin
      if (xi >= yi) begin
        if (-xi >= yi) d[brea_pkg::DirDown] = 1'b1;
        else d[brea_pkg::DirRight] = 1'b1;
      end else begin
        if (-xi >= yi) d[brea_pkg::DirLeft] = 1'b1;
        else d[brea_pkg::DirUp] = 1'b1;
      end
    end
    return d;
  endfunction

  // remap, edge detect and typematic repeat for one frame
  function automatic brea_pkg::result_t predict_result(input frame_t f);
    brea_pkg::btn_t    raw;
    brea_pkg::btn_t    held;
    brea_pkg::btn_t    fire;
    brea_pkg::cnt_t    c;
    brea_pkg::cnt_t    iv;
    int                b;
    brea_pkg::result_t r;
    raw  = f.raw;
    held = '0;
    fire = '0;
    if (regs.left_en) raw[3:0] = raw[3:0] | decode_stick(f.lx, f.ly);
    if (regs.right_en) begin
      raw[brea_pkg::RightBase +: 4] = raw[brea_pkg::RightBase +: 4] |
                                      decode_stick(f.rx, f.ry);
    end
    for (b = 0; b < brea_pkg::NumButtons; b++) begin
      if (raw[b]) held[regs.map[4*b +: 4]] = 1'b1;
    end
    for (b = 0; b < brea_pkg::NumButtons; b++) begin
      if (held[b]) begin
        c = countdown[b];
        if (c == regs.first_dly) fire[b] = 1'b1;
        countdown[b] = c - 8'd1;
        // countdown expired: fire and shrink the interval toward the floor
        if (c == 8'd1) begin
          iv           = interval[b];
          fire[b]      = 1'b1;
          countdown[b] = iv;
          interval[b]  = (iv <= regs.min_ivl) ? regs.min_ivl : iv - 8'd1;
        end
      end else begin
        countdown[b] = regs.first_dly;
        interval[b]  = regs.start_ivl;
      end
    end
    r.held     = held;
    r.pressed  = held & ~last_held;
    r.released = last_held & ~held;
    r.fire     = fire;
    last_held  = held;
    return r;
  endfunction

  // stick coordinate: full range, thresholds, extremes or near center
  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'(16383);
          1: return 16'(16382);
          2: return 16'(-16384);
          default: return 16'(-16385);
        endcase
      end
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      3: return 16'($urandom_range(0, 2000) - 1000);
      default: return '0;
    endcase
  endfunction

  task automatic check_field(input string name, input brea_pkg::btn_t exp_val,
                             input brea_pkg::btn_t got);
    if (exp_val !== got) begin
      $error("%s: expected %h, got %h", name, exp_val, got);
      mismatches++;
    end
  endtask

  // one register write; the predictor copy follows at once since nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      brea_pkg::RegLeftEn:   regs.left_en   = data[0];
      brea_pkg::RegRightEn:  regs.right_en  = data[0];
      brea_pkg::RegMap:      regs.map       = data;
      brea_pkg::RegFirstDly: regs.first_dly = data[7:0];
      brea_pkg::RegStartIvl: regs.start_ivl = data[7:0];
      brea_pkg::RegMinIvl:   regs.min_ivl   = data[7:0];
      default: ;
    endcase
  endtask

  // full register set, with junk in the unused upper bits and spare indexes
  task automatic apply_settings(input logic le, input logic re, input logic [63:0] map,
                                input brea_pkg::cnt_t first, input brea_pkg::cnt_t start,
                                input brea_pkg::cnt_t floor_ivl);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(RegSpare6, junk);
    write_reg(brea_pkg::RegLeftEn, {junk[63:1], le});
    write_reg(brea_pkg::RegRightEn, {junk[62:0], re});
    write_reg(brea_pkg::RegMap, map);
    write_reg(brea_pkg::RegFirstDly, {junk[63:8], first});
    write_reg(brea_pkg::RegStartIvl, {junk[55:0], start});
    write_reg(brea_pkg::RegMinIvl, {junk[59:4], floor_ivl});
    write_reg(RegSpare7, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_frame(input logic [15:0] raw, input logic [15:0] lx,
                           input logic [15:0] ly, input logic [15:0] rx,
                           input logic [15:0] ry);
    pending_frames.push_back(frame_t'{raw, lx, ly, rx, ry});
  endtask

  // random frames: buttons held across frames, flipped at noise plus churn per mille,
  // with noise per mille of frames carrying unrelated button words
  task automatic queue_frames(input int count, input int noise_pm, input int churn_pm);
    frame_t f;
    int     r;
    @(negedge clk_i);
    hold_mask = brea_pkg::btn_t'($urandom);
    repeat (count) begin
      r = $urandom_range(0, 999);
      if (r < noise_pm + churn_pm) begin
        hold_mask[$urandom_range(0, brea_pkg::NumButtons - 1)] ^= 1'b1;
      end else if (r < noise_pm + churn_pm + churn_pm / 20) begin
        hold_mask = '0;
      end else if (r < noise_pm + churn_pm + churn_pm / 10) begin
        hold_mask = brea_pkg::btn_t'($urandom);
      end
      if ($urandom_range(0, 999) < churn_pm) begin
        stick_lx = pick_axis();
        stick_ly = pick_axis();
      end
      if ($urandom_range(0, 999) < churn_pm) begin
        stick_rx = pick_axis();
        stick_ry = pick_axis();
      end
      f.raw = (r < noise_pm) ? 16'($urandom) : hold_mask;
      f.lx  = stick_lx;
      f.ly  = stick_ly;
      f.rx  = stick_rx;
      f.ry  = stick_ry;
      pending_frames.push_back(f);
    end
  endtask

  task automatic wait_idle();
    while (pending_frames.size() != 0 || push || predicted_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // frame driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predicted_results.push_back(predict_result(cur_frame));
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          cur_frame = pending_frames.pop_front();
          raw_buttons_i <= cur_frame.raw;
          left_x_i      <= cur_frame.lx;
          left_y_i      <= cur_frame.ly;
          right_x_i     <= cur_frame.rx;
          right_y_i     <= cur_frame.ry;
          push          <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each popped word, then pick the next pop
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_results.size() == 0) begin
          $error("result word with no prediction: held %h", held_o);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("held", want.held, held_o);
          check_field("pressed_edge", want.pressed, pressed_edge_o);
          check_field("released_edge", want.released, released_edge_o);
          check_field("repeat_fire", want.fire, repeat_fire_o);
        end
      end
      if (mode_left == 0) begin
        pop_mode  = pop_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        PopSteady:   pop <= 1'b1;
        PopCoin:     pop <= 1'($urandom_range(0, 1));
        PopPeriodic: pop <= (mode_left % 3 != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 30);
          end
        end
      endcase
    end
  end

  // watchdog on cycles with no progress on any port
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int p;
    regs.left_en   = 1'b0;
    regs.right_en  = 1'b0;
    regs.map       = brea_pkg::MapRst;
    regs.first_dly = brea_pkg::FirstDelayRst;
    regs.start_ivl = brea_pkg::StartIvlRst;
    regs.min_ivl   = brea_pkg::MinIvlRst;
    last_held      = '0;
    for (p = 0; p < brea_pkg::NumButtons; p++) begin
      countdown[p] = brea_pkg::FirstDelayRst;
      interval[p]  = brea_pkg::StartIvlRst;
    end
    stick_lx = '0;
    stick_ly = '0;
    stick_rx = '0;
    stick_ry = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: sticks ignored even at full deflection
    @(negedge clk_i);
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    add_frame(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h5555, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'hAAAA, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // stick decode: each direction, both sides of the left x thresholds, diagonals
    apply_settings(1'b1, 1'b1, brea_pkg::MapRst, brea_pkg::FirstDelayRst,
                   brea_pkg::StartIvlRst, brea_pkg::MinIvlRst);
    @(negedge clk_i);
    add_frame(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(16383), 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(16382), 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(-16384), 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(-16385), 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(20000), 16'(20000), 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'(-20000), 16'(-20000), 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'(16383));
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'(-16385));
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    add_frame(16'h00F0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    wait_idle();

    // every button mapped onto the same target
    apply_settings(1'b1, 1'b1, 64'h0, brea_pkg::FirstDelayRst,
                   brea_pkg::StartIvlRst, brea_pkg::MinIvlRst);
    @(negedge clk_i);
    add_frame(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // random phases over a spread of settings
    for (p = 0; p < 9; p++) begin
      case (p)
        0: begin
          apply_settings(1'b1, 1'b0, brea_pkg::MapRst, brea_pkg::FirstDelayRst,
                         brea_pkg::StartIvlRst, brea_pkg::MinIvlRst);
          queue_frames(150, 80, 200);
        end
        1: begin
          apply_settings(1'b0, 1'b1, brea_pkg::MapRst, 8'd2, 8'd1, 8'd1);
          queue_frames(120, 80, 200);
        end
        2: begin
          // long holds so the slowest repeat settings still fire
          apply_settings(1'b1, 1'b1, brea_pkg::MapRst, 8'd255, 8'd255, 8'd255);
          queue_frames(300, 0, 10);
        end
        3: begin
          // zero delay and intervals: counters wrap through 255
          apply_settings(1'b1, 1'b1, {$urandom, $urandom}, 8'd0, 8'd0, 8'd0);
          queue_frames(120, 80, 200);
        end
        4: begin
          apply_settings(1'b0, 1'b0, {$urandom, $urandom}, 8'd3, 8'd8, 8'd4);
          queue_frames(120, 150, 300);
        end
        5: begin
          apply_settings(1'($urandom), 1'($urandom), {$urandom, $urandom},
                         8'($urandom_range(0, 20)), 8'($urandom_range(0, 20)),
                         8'($urandom_range(0, 20)));
          queue_frames(120, 80, 200);
        end
        6: begin
          // floor above the starting interval
          apply_settings(1'b1, 1'b0, brea_pkg::MapRst, 8'd1, 8'd2, 8'd5);
          queue_frames(100, 80, 100);
        end
        7: begin
          apply_settings(1'b1, 1'b1, '1, 8'd4, 8'd3, 8'd1);
          queue_frames(60, 80, 200);
        end
        default: begin
          apply_settings(1'($urandom), 1'($urandom), {$urandom, $urandom},
                         8'($urandom), 8'($urandom), 8'($urandom));
          queue_frames(100, 80, 200);
        end
      endcase
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
